>>> hw/rtl/pcna_pkg.sv
package pcna_pkg;

    localparam logic [1:0] MODE_CORNER = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [15:0] COUNT_FULL = 16'hFFFF;
    localparam logic [15:0] Q_MAX      = 16'd32767;

    localparam logic KIND_CORNER = 1'b0;
    localparam logic KIND_POINT  = 1'b1;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] prev_x;
        logic signed [31:0] prev_y;
        logic signed [31:0] prev_z;
        logic signed [31:0] cur_x;
        logic signed [31:0] cur_y;
        logic signed [31:0] cur_z;
        logic signed [31:0] next_x;
        logic signed [31:0] next_y;
        logic signed [31:0] next_z;
        logic [11:0]        point_index;
        logic [15:0]        corner_index;
    } t_in;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               result_kind;
        logic [15:0]        tag_index;
        logic               degenerate;
    } t_out;

    typedef struct packed {
        logic smooth_enable;
    } t_cfg;

    typedef enum logic [2:0] {
        CLS_FLAT,
        CLS_SMOOTH,
        CLS_READ,
        CLS_READ_BAD,
        CLS_CLEAR,
        CLS_DROP
    } t_cls;

    typedef struct packed {
        t_cls               cls;
        logic signed [32:0] e1_x;
        logic signed [32:0] e1_y;
        logic signed [32:0] e1_z;
        logic signed [32:0] e2_x;
        logic signed [32:0] e2_y;
        logic signed [32:0] e2_z;
        logic [11:0]        pt;
        logic [15:0]        tag;
    } t_item;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic [15:0]        cnt;
    } t_entry;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CROSS,
        ST_NORM,
        ST_SQUARE,
        ST_SQRT,
        ST_DIV_LOAD,
        ST_DIV,
        ST_FINISH,
        ST_FETCH,
        ST_LOOKUP,
        ST_EMIT
    } t_state;

endpackage

>>> hw/rtl/pcna_chan_if.sv
interface pcna_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

>>> hw/rtl/pcna_front.sv
module pcna_front #(
    parameter int MAX_POINTS = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_smooth,
    pcna_chan_if.sink           i_in,
    input  logic                i_pop,
    output logic                o_avail,
    output pcna_pkg::t_item     o_item
);

    pcna_pkg::t_item r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            n_wp, n_rp;
    logic [1:0]      n_cnt;

    pcna_pkg::t_item item;
    logic            pt_ok;
    logic            accept;
    logic            push;

    assign i_in.ready = (r_cnt != 2'd2);
    assign accept     = i_in.valid && i_in.ready;
    assign pt_ok      = 32'(i_in.data.point_index) < 32'(MAX_POINTS);

    always_comb begin
        item.e1_x = {i_in.data.prev_x[31], i_in.data.prev_x} - {i_in.data.cur_x[31], i_in.data.cur_x};
        item.e1_y = {i_in.data.prev_y[31], i_in.data.prev_y} - {i_in.data.cur_y[31], i_in.data.cur_y};
        item.e1_z = {i_in.data.prev_z[31], i_in.data.prev_z} - {i_in.data.cur_z[31], i_in.data.cur_z};
        item.e2_x = {i_in.data.next_x[31], i_in.data.next_x} - {i_in.data.cur_x[31], i_in.data.cur_x};
        item.e2_y = {i_in.data.next_y[31], i_in.data.next_y} - {i_in.data.cur_y[31], i_in.data.cur_y};
        item.e2_z = {i_in.data.next_z[31], i_in.data.next_z} - {i_in.data.cur_z[31], i_in.data.cur_z};
        item.pt   = i_in.data.point_index;
        item.tag  = i_in.data.corner_index;
        unique case (i_in.data.mode)
            pcna_pkg::MODE_CORNER: begin
                if (!i_smooth) begin
                    item.cls = pcna_pkg::CLS_FLAT;
                end else begin
                    item.cls = pt_ok ? pcna_pkg::CLS_SMOOTH : pcna_pkg::CLS_DROP;
                end
            end
            pcna_pkg::MODE_READ: begin
                item.cls = pt_ok ? pcna_pkg::CLS_READ : pcna_pkg::CLS_READ_BAD;
                item.tag = {4'b0, i_in.data.point_index};
            end
            pcna_pkg::MODE_CLEAR: begin
                item.cls = pt_ok ? pcna_pkg::CLS_CLEAR : pcna_pkg::CLS_DROP;
            end
            default: begin
                item.cls = pcna_pkg::CLS_DROP;
            end
        endcase
    end

    // Words that produce nothing and change nothing never enter the queue.
    assign push = accept && (item.cls != pcna_pkg::CLS_DROP);

    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = i_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

endmodule

>>> hw/rtl/pcna_back.sv
module pcna_back #(
    parameter int MAX_POINTS = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_avail,
    input  pcna_pkg::t_item     i_item,
    output logic                o_pop,
    pcna_chan_if.source         o_out
);

    localparam int DEPTH = (MAX_POINTS < 4096) ? MAX_POINTS : 4096;
    localparam int AW    = $clog2(DEPTH);

    pcna_pkg::t_entry mem [DEPTH];
    pcna_pkg::t_entry r_rd;
    logic             mem_re, mem_we;
    logic [AW-1:0]    mem_wa;
    pcna_pkg::t_entry mem_wd;

    pcna_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    pcna_pkg::t_cls   r_cls, n_cls;
    logic [11:0]      r_pt, n_pt;
    logic [15:0]      r_tag, n_tag;
    logic signed [32:0] r_e1 [3];
    logic signed [32:0] r_e2 [3];
    logic signed [32:0] n_e1 [3];
    logic signed [32:0] n_e2 [3];
    logic [4:0]       r_cnt, n_cnt;
    logic signed [66:0] r_acc, n_acc;
    logic [65:0]      r_m [3];
    logic [65:0]      n_m [3];
    logic [2:0]       r_neg, n_neg;
    logic [63:0]      r_s, n_s;
    logic [63:0]      r_rem, n_rem;
    logic [63:0]      r_res, n_res;
    logic [63:0]      r_bit, n_bit;
    logic [31:0]      r_len, n_len;
    logic [32:0]      r_r, n_r;
    logic [15:0]      r_num, n_num;
    logic [15:0]      r_q, n_q;
    logic [1:0]       r_comp, n_comp;
    logic signed [15:0] r_n [3];
    logic signed [15:0] n_n [3];
    logic             r_deg, n_deg;
    logic             r_ov, n_ov;
    pcna_pkg::t_out   r_od, n_od;

    logic signed [32:0] op_a, op_b;
    logic signed [65:0] prod;
    logic signed [66:0] diff;
    logic [65:0]        orm;
    logic [61:0]        sq;
    logic [63:0]        trial;
    logic [47:0]        num;
    logic [32:0]        sh;
    logic               ge;
    logic [15:0]        q_next, q_sat;
    logic [31:0]        abs_x, abs_y, abs_z;
    logic               out_free;

    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;
    assign out_free    = !r_ov || o_out.ready;

    // Operand pairs of the cross product, one product per cycle.
    always_comb begin
        case (r_cnt[2:0])
            3'd0:    begin op_a = r_e1[1]; op_b = r_e2[2]; end
            3'd1:    begin op_a = r_e1[2]; op_b = r_e2[1]; end
            3'd2:    begin op_a = r_e1[2]; op_b = r_e2[0]; end
            3'd3:    begin op_a = r_e1[0]; op_b = r_e2[2]; end
            3'd4:    begin op_a = r_e1[0]; op_b = r_e2[1]; end
            default: begin op_a = r_e1[1]; op_b = r_e2[0]; end
        endcase
        prod  = op_a * op_b;
        diff  = r_acc - 67'(prod);
        orm   = r_m[0] | r_m[1] | r_m[2];
        sq    = r_m[r_cnt[1:0]][30:0] * r_m[r_cnt[1:0]][30:0];
        trial = r_res + r_bit;
        num   = {2'b0, r_m[r_comp][30:0], 15'b0} + {17'b0, r_len[31:1]};
        sh    = {r_r[31:0], r_num[15]};
        ge    = sh >= {1'b0, r_len};
        q_next = {r_q[14:0], ge};
        q_sat  = (q_next > pcna_pkg::Q_MAX) ? pcna_pkg::Q_MAX : q_next;
        abs_x = r_rd.sx[31] ? 32'(-r_rd.sx) : 32'(r_rd.sx);
        abs_y = r_rd.sy[31] ? 32'(-r_rd.sy) : 32'(r_rd.sy);
        abs_z = r_rd.sz[31] ? 32'(-r_rd.sz) : 32'(r_rd.sz);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pcna_pkg::ST_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) n_state = pcna_pkg::ST_IDLE;
            end
            pcna_pkg::ST_IDLE: begin
                if (i_avail) begin
                    case (i_item.cls) inside
                        pcna_pkg::CLS_FLAT, pcna_pkg::CLS_SMOOTH: n_state = pcna_pkg::ST_CROSS;
                        pcna_pkg::CLS_READ:     n_state = pcna_pkg::ST_FETCH;
                        pcna_pkg::CLS_READ_BAD: n_state = pcna_pkg::ST_EMIT;
                        default:                n_state = pcna_pkg::ST_IDLE;
                    endcase
                end
            end
            pcna_pkg::ST_CROSS: begin
                if (r_cnt == 5'd5) n_state = pcna_pkg::ST_NORM;
            end
            pcna_pkg::ST_NORM: begin
                if (orm == '0) begin
                    n_state = pcna_pkg::ST_FINISH;
                end else if (orm[65:31] == '0 && orm[30]) begin
                    n_state = pcna_pkg::ST_SQUARE;
                end
            end
            pcna_pkg::ST_SQUARE: begin
                if (r_cnt == 5'd2) n_state = pcna_pkg::ST_SQRT;
            end
            pcna_pkg::ST_SQRT: begin
                if (r_cnt == 5'd31) n_state = pcna_pkg::ST_DIV_LOAD;
            end
            pcna_pkg::ST_DIV_LOAD: begin
                n_state = pcna_pkg::ST_DIV;
            end
            pcna_pkg::ST_DIV: begin
                if (r_cnt == 5'd15) begin
                    n_state = (r_comp == 2'd2) ? pcna_pkg::ST_FINISH : pcna_pkg::ST_DIV_LOAD;
                end
            end
            pcna_pkg::ST_FINISH: begin
                n_state = (r_cls == pcna_pkg::CLS_SMOOTH) ? pcna_pkg::ST_FETCH
                                                          : pcna_pkg::ST_EMIT;
            end
            pcna_pkg::ST_FETCH: begin
                n_state = pcna_pkg::ST_LOOKUP;
            end
            pcna_pkg::ST_LOOKUP: begin
                if (r_cls == pcna_pkg::CLS_SMOOTH) begin
                    n_state = pcna_pkg::ST_IDLE;
                end else if (r_rd.cnt == 16'd0) begin
                    n_state = pcna_pkg::ST_EMIT;
                end else begin
                    n_state = pcna_pkg::ST_NORM;
                end
            end
            pcna_pkg::ST_EMIT: begin
                if (out_free) n_state = pcna_pkg::ST_IDLE;
            end
            default: n_state = pcna_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_clr  = r_clr;
        n_cls  = r_cls;
        n_pt   = r_pt;
        n_tag  = r_tag;
        n_e1   = r_e1;
        n_e2   = r_e2;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_m    = r_m;
        n_neg  = r_neg;
        n_s    = r_s;
        n_rem  = r_rem;
        n_res  = r_res;
        n_bit  = r_bit;
        n_len  = r_len;
        n_r    = r_r;
        n_num  = r_num;
        n_q    = r_q;
        n_comp = r_comp;
        n_n    = r_n;
        n_deg  = r_deg;
        n_ov   = (r_ov && o_out.ready) ? 1'b0 : r_ov;
        n_od   = r_od;
        o_pop  = 1'b0;
        mem_re = 1'b0;
        mem_we = 1'b0;
        mem_wa = r_pt[AW-1:0];
        mem_wd = '0;

        unique case (r_state)
            pcna_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                n_clr  = r_clr + AW'(1);
            end
            pcna_pkg::ST_IDLE: begin
                if (i_avail) begin
                    o_pop  = 1'b1;
                    n_cls  = i_item.cls;
                    n_pt   = i_item.pt;
                    n_tag  = i_item.tag;
                    n_e1[0] = i_item.e1_x;
                    n_e1[1] = i_item.e1_y;
                    n_e1[2] = i_item.e1_z;
                    n_e2[0] = i_item.e2_x;
                    n_e2[1] = i_item.e2_y;
                    n_e2[2] = i_item.e2_z;
                    n_cnt  = 5'd0;
                    n_n[0] = '0;
                    n_n[1] = '0;
                    n_n[2] = '0;
                    n_deg  = 1'b1;
                    if (i_item.cls == pcna_pkg::CLS_CLEAR) begin
                        mem_we = 1'b1;
                        mem_wa = i_item.pt[AW-1:0];
                    end
                end
            end
            pcna_pkg::ST_CROSS: begin
                n_cnt = r_cnt + 5'd1;
                if (!r_cnt[0]) begin
                    n_acc = 67'(prod);
                end else begin
                    n_neg[r_cnt[2:1]] = diff[66];
                    n_m[r_cnt[2:1]]   = diff[66] ? 66'(-diff) : diff[65:0];
                end
            end
            pcna_pkg::ST_NORM: begin
                n_cnt = 5'd0;
                n_s   = '0;
                n_deg = (orm == '0);
                // Step the largest magnitude toward a bit length of 31.
                if (orm[65:31] != '0) begin
                    for (int i = 0; i < 3; i++) n_m[i] = r_m[i] >> 1;
                end else if (orm != '0 && !orm[30]) begin
                    for (int i = 0; i < 3; i++) n_m[i] = r_m[i] << 1;
                end
            end
            pcna_pkg::ST_SQUARE: begin
                n_s   = r_s + 64'(sq);
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd2) begin
                    n_cnt = 5'd0;
                    n_rem = r_s + 64'(sq);
                    n_res = '0;
                    n_bit = 64'h4000_0000_0000_0000;
                end
            end
            pcna_pkg::ST_SQRT: begin
                n_cnt = r_cnt + 5'd1;
                n_bit = r_bit >> 2;
                if (r_rem >= trial) begin
                    n_rem = r_rem - trial;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_len  = n_res[31:0];
                n_comp = 2'd0;
            end
            pcna_pkg::ST_DIV_LOAD: begin
                n_r   = {1'b0, num[47:16]};
                n_num = num[15:0];
                n_q   = '0;
                n_cnt = 5'd0;
            end
            pcna_pkg::ST_DIV: begin
                n_cnt = r_cnt + 5'd1;
                n_num = {r_num[14:0], 1'b0};
                n_r   = ge ? sh - {1'b0, r_len} : sh;
                n_q   = q_next;
                if (r_cnt == 5'd15) begin
                    n_n[r_comp] = r_neg[r_comp] ? -$signed(q_sat) : $signed(q_sat);
                    n_comp      = r_comp + 2'd1;
                end
            end
            pcna_pkg::ST_FINISH: begin
            end
            pcna_pkg::ST_FETCH: begin
                mem_re = 1'b1;
            end
            pcna_pkg::ST_LOOKUP: begin
                if (r_cls == pcna_pkg::CLS_SMOOTH) begin
                    // A full count freezes the entry so the sums cannot overflow.
                    if (r_rd.cnt != pcna_pkg::COUNT_FULL) begin
                        mem_we    = 1'b1;
                        mem_wd.sx = r_rd.sx + 32'(r_n[0]);
                        mem_wd.sy = r_rd.sy + 32'(r_n[1]);
                        mem_wd.sz = r_rd.sz + 32'(r_n[2]);
                        mem_wd.cnt = r_rd.cnt + 16'd1;
                    end
                end else if (r_rd.cnt != 16'd0) begin
                    n_m[0] = {34'b0, abs_x};
                    n_m[1] = {34'b0, abs_y};
                    n_m[2] = {34'b0, abs_z};
                    n_neg  = {r_rd.sz[31], r_rd.sy[31], r_rd.sx[31]};
                end
            end
            pcna_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_od.normal_x    = r_n[0];
                    n_od.normal_y    = r_n[1];
                    n_od.normal_z    = r_n[2];
                    n_od.result_kind = (r_cls == pcna_pkg::CLS_FLAT) ? pcna_pkg::KIND_CORNER
                                                                     : pcna_pkg::KIND_POINT;
                    n_od.tag_index   = r_tag;
                    n_od.degenerate  = r_deg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcna_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls  <= n_cls;
        r_pt   <= n_pt;
        r_tag  <= n_tag;
        r_e1   <= n_e1;
        r_e2   <= n_e2;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_m    <= n_m;
        r_neg  <= n_neg;
        r_s    <= n_s;
        r_rem  <= n_rem;
        r_res  <= n_res;
        r_bit  <= n_bit;
        r_len  <= n_len;
        r_r    <= n_r;
        r_num  <= n_num;
        r_q    <= n_q;
        r_comp <= n_comp;
        r_n    <= n_n;
        r_deg  <= n_deg;
        r_od   <= n_od;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[r_pt[AW-1:0]];
        end
    end

endmodule

>>> hw/rtl/polygon_corner_normal_accumulator.sv
// Channel   Dir   Payload                      Handshake
// i_in      in    pcna_pkg::t_in (one item)    valid/ready
// o_out     out   pcna_pkg::t_out (one result) valid/ready
// i_cfg     in    pcna_pkg::t_cfg              valid/ready, ready always high
//
// In the back end a corner word takes six products on one 33x33 multiplier, a normalizing shift
// of one bit per step, three squares, 32 square-root steps and three restoring divisions, or
// goes straight from the products to the finish with a zero cross product. A read fetches its
// stored entry in place of the cross product; a clear is written as it is taken from the queue.
// After reset the point store is swept to zero, one entry a cycle, over min(MAX_POINTS, 4096)
// entries; a two-word queue lets the front keep taking words while the back end stalls.
module polygon_corner_normal_accumulator #(
    parameter int MAX_POINTS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcna_chan_if.sink   i_in,
    pcna_chan_if.source o_out,
    pcna_chan_if.sink   i_cfg
);

    logic            r_smooth;
    logic            pop;
    logic            avail;
    pcna_pkg::t_item item;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= 1'b0;
        end else if (i_cfg.valid) begin
            r_smooth <= i_cfg.data.smooth_enable;
        end
    end

    pcna_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_smooth (r_smooth),
        .i_in     (i_in),
        .i_pop    (pop),
        .o_avail  (avail),
        .o_item   (item)
    );

    pcna_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_item  (item),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
